// File: src/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 7;

    localparam logic signed [KEY_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic                    ins;
        logic                    ext;
        logic signed [KEY_W-1:0] key;
    } op_t;

endpackage

`default_nettype wire

// File: src/mhpq_cell.sv
`default_nettype none

module mhpq_cell (
    input  wire logic                            aclk,
    input  wire mhpq_pkg::op_t                   op,
    input  wire logic                            in_range,
    input  wire logic                            at_tail,
    input  wire logic                            left_gt,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] left_key,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] right_key,
    output logic                                 gt,
    output logic signed [mhpq_pkg::KEY_W-1:0]    key
);

    logic signed [mhpq_pkg::KEY_W-1:0] key_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_next;

    // The chain is kept sorted, so the cells holding larger keys form one run.
    assign gt  = in_range && (key_reg > op.key);
    assign key = key_reg;

    always_comb begin
        key_next = key_reg;
        if (op.ins && (gt || at_tail)) begin
            // The first larger cell takes the new key; the rest take from the left.
            key_next = left_gt ? left_key : op.key;
        end else if (op.ext) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// File: src/min_heap_priority_queue_core.sv
// Priority queue over signed 32-bit keys, smallest key first.
// Input requests arrive on the s_ channel: s_tuser carries the command (insert or
// extract the minimum) and s_tdata the key, which an extract ignores.
// Every request gives exactly one result on the m_ channel: the extracted key,
// the root after the request, the entry count, and a status in m_tuser (done,
// insert dropped because full, extract on an empty queue).
// The keys sit in a chain of DEPTH cells kept in sorted order; an insert shifts
// the larger keys one cell to the right and an extract shifts every key one cell
// to the left, with every cell register updating at once.
// The result is registered, appearing in the cycle after the request is taken;
// a request can be taken in every cycle while m_tready is high, as the result
// register frees itself in that cycle, so the rate is set by that register alone.
// If the receiver stalls, the result is held and s_tready falls until it is taken.
// The capacity limit is written through cfg_wr_en/cfg_wr_data only while the block is
// idle, a rule for the user that the block does not enforce; values above DEPTH act as DEPTH.
// Reset empties the queue, sets the limit to 64 and drops any pending result;
// no clearing pass is needed, as cells beyond the count are never read.
`default_nettype none

module min_heap_priority_queue_core #(
    parameter int DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] key_in
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] extracted_key, [63:32] current_min,
                                        // [70:64] entry_count, [71] zero
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data
);

    localparam int KW = mhpq_pkg::KEY_W;
    localparam int CW = mhpq_pkg::CNT_W;

    logic [CW-1:0]          occupancy_reg, occupancy_next;
    logic [CW-1:0]          limit_reg;
    logic [CW-1:0]          limit_eff;
    logic                   out_valid_reg;
    logic signed [KW-1:0]   extracted_reg, extracted_next;
    logic signed [KW-1:0]   min_reg, min_next;
    logic [CW-1:0]          count_reg;
    mhpq_pkg::status_t      status_reg, status_next;

    logic                   accept;
    logic                   heap_full;
    logic                   heap_empty;
    logic signed [KW-1:0]   in_key;
    mhpq_pkg::op_t          op;

    logic signed [KW-1:0]   cell_key [DEPTH];
    logic                   cell_gt  [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_key   = $signed(s_tdata);

    assign limit_eff  = (32'(limit_reg) > DEPTH) ? CW'(DEPTH) : limit_reg;
    assign heap_full  = (occupancy_reg >= limit_eff);
    assign heap_empty = (occupancy_reg == '0);

    assign op.ins = accept && (s_tuser[0] == mhpq_pkg::CMD_INSERT) && !heap_full;
    assign op.ext = accept && (s_tuser[0] == mhpq_pkg::CMD_EXTRACT) && !heap_empty;
    assign op.key = in_key;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                 left_gt;
            logic signed [KW-1:0] left_key;
            logic signed [KW-1:0] right_key;

            if (g == 0) begin : g_head
                assign left_gt  = 1'b0;
                assign left_key = in_key;
            end else begin : g_body
                assign left_gt  = cell_gt[g-1];
                assign left_key = cell_key[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign right_key = mhpq_pkg::INT_MAX;
            end else begin : g_inner
                assign right_key = cell_key[g+1];
            end

            mhpq_cell u_cell (
                .aclk      (aclk),
                .op        (op),
                .in_range  (32'(g) < 32'(occupancy_reg)),
                .at_tail   (32'(g) == 32'(occupancy_reg)),
                .left_gt   (left_gt),
                .left_key  (left_key),
                .right_key (right_key),
                .gt        (cell_gt[g]),
                .key       (cell_key[g])
            );
        end
    endgenerate

    always_comb begin
        occupancy_next = occupancy_reg;
        extracted_next = mhpq_pkg::INT_MAX;
        status_next    = mhpq_pkg::ST_DONE;
        min_next       = heap_empty ? mhpq_pkg::INT_MAX : cell_key[0];
        if (s_tuser[0] == mhpq_pkg::CMD_INSERT) begin
            if (heap_full) begin
                status_next = mhpq_pkg::ST_FULL;
            end else begin
                occupancy_next = occupancy_reg + 1'b1;
                if (heap_empty || (cell_key[0] > in_key)) begin
                    min_next = in_key;
                end
            end
        end else begin
            if (heap_empty) begin
                status_next = mhpq_pkg::ST_EMPTY;
            end else begin
                occupancy_next = occupancy_reg - 1'b1;
                extracted_next = cell_key[0];
                min_next       = (occupancy_reg == CW'(1)) ? mhpq_pkg::INT_MAX : cell_key[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupancy_reg <= '0;
            limit_reg     <= mhpq_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                occupancy_reg <= occupancy_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            extracted_reg <= extracted_next;
            min_reg       <= min_next;
            count_reg     <= occupancy_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, count_reg, min_reg, extracted_reg};
    assign m_tuser  = status_reg;

    // The count never runs past the storage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occupancy_reg) <= DEPTH)
        else $error("occupancy exceeds storage depth");

    // The two front cells stay in order whenever both hold keys.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (occupancy_reg >= CW'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("cell chain out of order");

    // A successful insert grows the queue by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        op.ins |=> (occupancy_reg == $past(occupancy_reg) + 1'b1))
        else $error("insert did not grow occupancy by one");

    // An empty queue reports the largest key as its minimum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (count_reg == '0)) |-> (min_reg == mhpq_pkg::INT_MAX))
        else $error("empty queue reports a minimum key");

endmodule

`default_nettype wire
